@@ sv/frame_duration_sequencer_defines.svh @@
// ----------------------------------------------------------------------------
// Frame duration sequencer assertion macros
// Concurrent assertion wrappers, compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef FRAME_DURATION_SEQUENCER_DEFINES_SVH
`define FRAME_DURATION_SEQUENCER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define FDS_ASSERT_HOLDS(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("fds: assertion failed");
// next-cycle implication
`define FDS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("fds: assertion failed");
`else
`define FDS_ASSERT_HOLDS(label, clk, rst_n, ante, cons)
`define FDS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ sv/fds_pkg.sv @@
// ----------------------------------------------------------------------------
// Frame duration sequencer package
// Field widths, reset values, command and register codes.
// ----------------------------------------------------------------------------
package fds_pkg;

	localparam int DEF_MAX_FRAMES = 8;
	localparam int DEF_TIME_BITS  = 16;

	localparam int CMD_W         = 2;
	localparam int SLOT_W        = 3;
	localparam int TIME_W        = 16;
	localparam int FRAME_W       = 3;
	localparam int FRAME_COUNT_W = 4;
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 16;

	localparam logic [FRAME_COUNT_W-1:0] FRAME_COUNT_RST = '0;
	localparam logic                     LOOP_RST        = 1'b1;
	localparam logic [TIME_W-1:0]        CLAMP_LIMIT_RST = 16'd200;
	localparam logic [TIME_W-1:0]        CLAMP_VALUE_RST = 16'd80;

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK    = 2'd0,
		CMD_LOAD    = 2'd1,
		CMD_RESTART = 2'd2
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FRAME_COUNT = 2'd0,
		CFG_LOOP_ENABLE = 2'd1,
		CFG_CLAMP_LIMIT = 2'd2,
		CFG_CLAMP_VALUE = 2'd3
	} cfg_idx_t;

endpackage

@@ sv/fds_req_if.sv @@
// ----------------------------------------------------------------------------
// Frame duration sequencer request channel
// Valid/ready channel carrying one command request.
// ----------------------------------------------------------------------------
interface fds_req_if;
	import fds_pkg::*;

	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  command;
	logic [SLOT_W-1:0] slot;
	logic [TIME_W-1:0] duration;
	logic [TIME_W-1:0] delta;
	logic [TIME_W-1:0] start_delay;
	logic [TIME_W-1:0] start_phase;

	modport source (
		output valid, command, slot, duration, delta, start_delay, start_phase,
		input  ready
	);
	modport sink (
		input  valid, command, slot, duration, delta, start_delay, start_phase,
		output ready
	);
endinterface

@@ sv/fds_rsp_if.sv @@
// ----------------------------------------------------------------------------
// Frame duration sequencer response channel
// Valid/ready channel carrying the sequencer status after each request.
// ----------------------------------------------------------------------------
interface fds_rsp_if;
	import fds_pkg::*;

	logic               valid;
	logic               ready;
	logic [FRAME_W-1:0] frame;
	logic               done_res;
	logic               waiting;
	logic               showing;

	modport source (
		output valid, frame, done_res, waiting, showing,
		input  ready
	);
	modport sink (
		input  valid, frame, done_res, waiting, showing,
		output ready
	);
endinterface

@@ sv/frame_duration_sequencer.sv @@
// Flow: load, restart, unused and finished or frameless ticks go straight to EMIT; other
// ticks pass DLY while a delay runs (ending if it absorbs them), else ADD, then SUBD if it ends,
// CHK, and FETCH (table read) and STEP (compare/subtract on the shared adder) per frame entry.
// Throughput: one request at a time; req.ready returns as the result is registered, and
// an unaccepted result holds off the next one. Reset: arst_n clears control state and
// config (loop on, clamp 200 -> 80) at once; the duration table is undefined until loaded.
// ----------------------------------------------------------------------------
// Frame duration sequencer
// Steps through a table of programmable frame durations under tick requests,
// using one shared adder under a small sequencer.
// ----------------------------------------------------------------------------
`include "frame_duration_sequencer_defines.svh"

module frame_duration_sequencer #(
	parameter int MAX_FRAMES = fds_pkg::DEF_MAX_FRAMES,
	parameter int TIME_BITS  = fds_pkg::DEF_TIME_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	fds_req_if.sink                       req,
	fds_rsp_if.source                     rsp,
	input  logic                          cfg_we,
	input  logic [fds_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fds_pkg::CFG_DATA_W-1:0] cfg_data
);
	import fds_pkg::*;

	localparam int FW   = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
	localparam int CW   = $clog2(MAX_FRAMES + 1);
	localparam int ET_W = TIME_BITS + 1;
	localparam int UW   = TIME_BITS + 2;

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_DLY   = 8'b0000_0010,
		ST_ADD   = 8'b0000_0100,
		ST_SUBD  = 8'b0000_1000,
		ST_CHK   = 8'b0001_0000,
		ST_FETCH = 8'b0010_0000,
		ST_STEP  = 8'b0100_0000,
		ST_EMIT  = 8'b1000_0000
	} state_t;

	state_t                   state_q;
	logic [FRAME_COUNT_W-1:0] frame_count_q;
	logic                     loop_q;
	logic [TIME_W-1:0]        clamp_limit_q;
	logic [TIME_W-1:0]        clamp_value_q;

	logic [CW-1:0]        frame_q;
	logic [ET_W-1:0]      elapsed_q;
	logic [TIME_BITS-1:0] delay_q;
	logic                 finished_q;
	logic [TIME_BITS-1:0] delta_q;

	logic               out_valid_q;
	logic [FRAME_W-1:0] out_frame_q;
	logic               out_done_q;
	logic               out_waiting_q;
	logic               out_showing_q;

	logic                 accept;
	logic                 emit_fire;
	logic [TIME_W-1:0]    delta_clamped;
	logic [CW-1:0]        cnt;
	logic [CW-1:0]        frame_nx;
	logic [TIME_BITS-1:0] rd_data;
	logic [TIME_BITS-1:0] len;
	logic                 tbl_we;
	logic                 tbl_re;

	logic [UW-1:0] alu_a;
	logic [UW-1:0] alu_b;
	logic          alu_sub;
	logic [UW-1:0] alu_res;
	logic          borrow;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_count_q <= FRAME_COUNT_RST;
			loop_q        <= LOOP_RST;
			clamp_limit_q <= CLAMP_LIMIT_RST;
			clamp_value_q <= CLAMP_VALUE_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_FRAME_COUNT: frame_count_q <= cfg_data[FRAME_COUNT_W-1:0];
				CFG_LOOP_ENABLE: loop_q        <= cfg_data[0];
				CFG_CLAMP_LIMIT: clamp_limit_q <= cfg_data[TIME_W-1:0];
				CFG_CLAMP_VALUE: clamp_value_q <= cfg_data[TIME_W-1:0];
				default: ;
			endcase
		end
	end

	assign req.ready     = (state_q == ST_IDLE);
	assign accept        = req.valid && req.ready;
	assign emit_fire     = (state_q == ST_EMIT) && (!out_valid_q || rsp.ready);
	assign delta_clamped = (req.delta > clamp_limit_q) ? clamp_value_q : req.delta;
	assign cnt           = (32'(frame_count_q) > MAX_FRAMES) ? CW'(MAX_FRAMES)
	                                                        : CW'(frame_count_q);
	assign frame_nx      = frame_q + CW'(1);
	// an empty entry lasts one millisecond
	assign len           = (rd_data == '0) ? TIME_BITS'(1) : rd_data;

	assign tbl_we = accept && (req.command == CMD_LOAD) && (32'(req.slot) < MAX_FRAMES);
	assign tbl_re = (state_q == ST_FETCH);

	fds_ram #(
		.WIDTH (TIME_BITS),
		.DEPTH (MAX_FRAMES)
	) u_table (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (FW'(req.slot)),
		.wdata (TIME_BITS'(req.duration)),
		.re    (tbl_re),
		.raddr (frame_q[FW-1:0]),
		.rdata (rd_data)
	);

	// shared add/subtract unit
	always_comb begin
		alu_a   = '0;
		alu_b   = '0;
		alu_sub = 1'b0;
		unique case (state_q)
			ST_DLY: begin
				alu_a   = UW'(delay_q);
				alu_b   = UW'(delta_q);
				alu_sub = 1'b1;
			end
			ST_ADD: begin
				alu_a = UW'(elapsed_q);
				alu_b = UW'(delta_q);
			end
			ST_SUBD: begin
				alu_a   = UW'(elapsed_q);
				alu_b   = UW'(delay_q);
				alu_sub = 1'b1;
			end
			ST_STEP: begin
				alu_a   = UW'(elapsed_q);
				alu_b   = UW'(len);
				alu_sub = 1'b1;
			end
			default: ;
		endcase
	end

	assign alu_res = alu_a + (alu_sub ? ~alu_b : alu_b) + UW'(alu_sub);
	assign borrow  = alu_res[UW-1];

	always_ff @(posedge clk) begin
		if (accept) begin
			delta_q <= TIME_BITS'(delta_clamped);
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			frame_q    <= '0;
			elapsed_q  <= '0;
			delay_q    <= '0;
			finished_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (req.command)
							CMD_TICK: begin
								if (finished_q) begin
									state_q <= ST_EMIT;
								end else if (cnt == '0) begin
									finished_q <= 1'b1;
									state_q    <= ST_EMIT;
								end else if (delay_q != '0) begin
									state_q <= ST_DLY;
								end else begin
									state_q <= ST_ADD;
								end
							end
							CMD_RESTART: begin
								frame_q    <= '0;
								elapsed_q  <= ET_W'(TIME_BITS'(req.start_phase));
								delay_q    <= TIME_BITS'(req.start_delay);
								finished_q <= 1'b0;
								state_q    <= ST_EMIT;
							end
							default: state_q <= ST_EMIT;
						endcase
					end
				end
				ST_DLY: begin
					// delay still running: tick fully absorbed
					if (!borrow && (alu_res != '0)) begin
						delay_q <= alu_res[TIME_BITS-1:0];
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_ADD;
					end
				end
				ST_ADD: begin
					elapsed_q <= alu_res[ET_W-1:0];
					state_q   <= (delay_q != '0) ? ST_SUBD : ST_CHK;
				end
				ST_SUBD: begin
					elapsed_q <= alu_res[ET_W-1:0];
					delay_q   <= '0;
					state_q   <= ST_CHK;
				end
				ST_CHK: begin
					// frame may sit past the end if the count was lowered
					if (frame_q >= cnt) begin
						if (loop_q) begin
							frame_q <= '0;
							state_q <= ST_FETCH;
						end else begin
							finished_q <= 1'b1;
							state_q    <= ST_EMIT;
						end
					end else begin
						state_q <= ST_FETCH;
					end
				end
				ST_FETCH: state_q <= ST_STEP;
				ST_STEP: begin
					if (!borrow) begin
						elapsed_q <= alu_res[ET_W-1:0];
						if (frame_nx >= cnt) begin
							if (loop_q) begin
								frame_q <= '0;
								state_q <= ST_FETCH;
							end else begin
								frame_q    <= frame_nx;
								finished_q <= 1'b1;
								state_q    <= ST_EMIT;
							end
						end else begin
							frame_q <= frame_nx;
							state_q <= ST_FETCH;
						end
					end else begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit_fire) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_fire) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			out_frame_q   <= FRAME_W'(frame_q);
			out_done_q    <= finished_q;
			out_waiting_q <= !finished_q && (delay_q != '0);
			out_showing_q <= !finished_q && (delay_q == '0);
		end
	end

	assign rsp.valid    = out_valid_q;
	assign rsp.frame    = out_frame_q;
	assign rsp.done_res = out_done_q;
	assign rsp.waiting  = out_waiting_q;
	assign rsp.showing  = out_showing_q;

	`FDS_ASSERT_HOLDS(a_step_frame_in_range, clk, arst_n, state_q == ST_STEP, frame_q < cnt)
	`FDS_ASSERT_HOLDS(a_idle_elapsed_fits, clk, arst_n, state_q == ST_IDLE && !finished_q, elapsed_q[TIME_BITS] == 1'b0)
	`FDS_ASSERT_NEXT(a_request_leaves_idle, clk, arst_n, req.valid && req.ready, state_q != ST_IDLE)
	`FDS_ASSERT_NEXT(a_emit_loads_result, clk, arst_n, emit_fire, rsp.valid && state_q == ST_IDLE)

endmodule

@@ sv/fds_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module fds_ram #(
	parameter  int WIDTH = 16,
	parameter  int DEPTH = 8,
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
